>>> sv/supply_voltage_and_plug_detect_macros.svh
// assertion macros for the supply voltage and plug detect block
`ifndef SUPPLY_VOLTAGE_AND_PLUG_DETECT_MACROS_SVH
`define SUPPLY_VOLTAGE_AND_PLUG_DETECT_MACROS_SVH

// clocked check, switched off while reset is asserted
`define SVPD_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked check that also holds while reset is asserted
`define SVPD_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> sv/svpd_pkg.sv
package svpd_pkg;

  // default adc sample width
  localparam int SAMPLE_BITS_DEF = 12;

  // calibration arithmetic
  localparam int CAL_BITS      = 12;
  localparam int CAL_MUL_BITS  = 9;
  localparam int CAL_CENTIVOLTS = 300;
  localparam int VOLT_BITS     = 16;
  localparam int SAT_MAX       = 65535;
  localparam int SAT_HALF      = 32767;

  // configuration register indexes
  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] REG_CAL = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_LAG = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_HUB = 2'd2;

  // configuration reset values
  localparam logic [CAL_BITS-1:0] CAL_RESET = 12'd1671;
  localparam logic [31:0]         LAG_RESET = 32'd10000;
  localparam logic                HUB_RESET = 1'b0;

  // plug state codes
  localparam logic [1:0] PLUG_UNKNOWN = 2'd0;
  localparam logic [1:0] PLUG_IN      = 2'd1;
  localparam logic [1:0] PLUG_OUT     = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic accept;
    logic load;
    logic step;
    logic store;
    logic sel_pwr;
    logic publish;
  } svpd_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic hub;
    logic out_free;
  } svpd_sts_t;

endpackage

>>> sv/supply_voltage_and_plug_detect.sv
// each result comes from the shared one-bit-per-cycle restoring divider, used once per
//   measured rail: battery only outside hub mode, battery then power in hub mode, with
//   NW = 21 + SAMPLE_BITS quotient bits (33 at 12 bits); a new transaction is only
//   taken once the previous result has been published
// reset: asynchronous, active low; clears configuration registers to defaults and plug state to unknown
module supply_voltage_and_plug_detect
  import svpd_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration write channel
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [31:0]             cfg_data_i,
  // input channel
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [SAMPLE_BITS-1:0]  reference_raw_i,
  input  logic [SAMPLE_BITS-1:0]  power_raw_i,
  input  logic [SAMPLE_BITS-1:0]  battery_raw_i,
  input  logic [31:0]             now_ms_i,
  // output channel
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [VOLT_BITS-1:0]    battery_centivolts_o,
  output logic [VOLT_BITS-1:0]    power_centivolts_o,
  output logic [1:0]              plug_state_o,
  output logic                    range_error_o
);

  svpd_cmd_t cmd;
  svpd_sts_t sts;

  assign cfg_ready_o = 1'b1;

  // sequencer
  svpd_ctrl #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .cmd_o     (cmd),
    .sts_i     (sts)
  );

  // arithmetic, debounce and output register
  svpd_dp #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .reference_raw_i     (reference_raw_i),
    .power_raw_i         (power_raw_i),
    .battery_raw_i       (battery_raw_i),
    .now_ms_i            (now_ms_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .battery_centivolts_o(battery_centivolts_o),
    .power_centivolts_o  (power_centivolts_o),
    .plug_state_o        (plug_state_o),
    .range_error_o       (range_error_o),
    .cmd_i               (cmd),
    .sts_o               (sts)
  );

endmodule

>>> sv/svpd_ctrl.sv
module svpd_ctrl
  import svpd_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output svpd_cmd_t cmd_o,
  input  svpd_sts_t sts_i
);

  localparam int NW = CAL_MUL_BITS + CAL_BITS + SAMPLE_BITS;
  localparam int CW = $clog2(NW);
  localparam logic [CW-1:0] CNT_LAST = CW'(NW - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_STORE = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          sel_q, sel_d;

  // sequencing of the conversions: battery only, or battery then power in hub mode
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    sel_d   = sel_q;
    cmd_o   = '0;
    cmd_o.sel_pwr = sel_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          sel_d   = 1'b0;
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        cnt_d   = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          state_d = S_STORE;
        end
      end
      S_STORE: begin
        cmd_o.store = 1'b1;
        if (!sel_q && sts_i.hub) begin
          sel_d   = 1'b1;
          state_d = S_LOAD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.publish = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      sel_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      sel_q   <= sel_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

>>> sv/svpd_dp.sv
module svpd_dp
  import svpd_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration
  input  logic                    cfg_valid_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [31:0]             cfg_data_i,
  // input transaction
  input  logic [SAMPLE_BITS-1:0]  reference_raw_i,
  input  logic [SAMPLE_BITS-1:0]  power_raw_i,
  input  logic [SAMPLE_BITS-1:0]  battery_raw_i,
  input  logic [31:0]             now_ms_i,
  // output transaction
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [VOLT_BITS-1:0]    battery_centivolts_o,
  output logic [VOLT_BITS-1:0]    power_centivolts_o,
  output logic [1:0]              plug_state_o,
  output logic                    range_error_o,
  // control
  input  svpd_cmd_t               cmd_i,
  output svpd_sts_t               sts_o
);

  localparam int PW = CAL_MUL_BITS + CAL_BITS;
  localparam int NW = PW + SAMPLE_BITS;
  localparam int DW = 2 * SAMPLE_BITS;

  // configuration registers
  logic [CAL_BITS-1:0] cal_q;
  logic [31:0]         lag_q;
  logic                hub_q;

  // item registers
  logic [SAMPLE_BITS-1:0] ref_q, pwr_raw_q, bat_raw_q;
  logic [31:0]            now_q;
  logic [PW-1:0]          cal300_q;
  logic [DW-1:0]          den_q, rem_q;
  logic [NW-1:0]          quo_q;
  logic [VOLT_BITS-1:0]   batt_q, pwr_q;
  logic                   err_q;

  // output and plug tracking registers
  logic                 out_valid_q;
  logic [VOLT_BITS-1:0] out_batt_q, out_pwr_q;
  logic                 out_err_q;
  logic [1:0]           prev_q, prev_d, acc_q, acc_d;
  logic [31:0]          change_q, change_d;

  logic [DW:0]            trial, diff;
  logic                   ge;
  logic [SAMPLE_BITS-1:0] raw_sel;
  logic [VOLT_BITS-1:0]   sat_val;
  logic                   sat_err;
  logic [1:0]             reading;
  logic [31:0]            elapsed;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= CAL_RESET;
      lag_q <= LAG_RESET;
      hub_q <= HUB_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_CAL: cal_q <= cfg_data_i[CAL_BITS-1:0];
        REG_LAG: lag_q <= cfg_data_i;
        REG_HUB: hub_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // restoring division step
  always_comb begin
    trial = {rem_q, quo_q[NW-1]};
    diff  = trial - {1'b0, den_q};
    ge    = (trial >= {1'b0, den_q});
  end

  assign raw_sel = cmd_i.sel_pwr ? pwr_raw_q : bat_raw_q;

  // saturation of the quotient, doubled in hub mode
  always_comb begin
    sat_val = quo_q[VOLT_BITS-1:0];
    sat_err = 1'b0;
    priority if (ref_q == '0) begin
      sat_val = VOLT_BITS'(SAT_MAX);
      sat_err = 1'b1;
    end else if (hub_q) begin
      if (quo_q > NW'(SAT_HALF)) begin
        sat_val = VOLT_BITS'(SAT_MAX);
        sat_err = 1'b1;
      end else begin
        sat_val = {quo_q[VOLT_BITS-2:0], 1'b0};
      end
    end else if (quo_q > NW'(SAT_MAX)) begin
      sat_val = VOLT_BITS'(SAT_MAX);
      sat_err = 1'b1;
    end else begin
      sat_val = quo_q[VOLT_BITS-1:0];
    end
  end

  // item datapath
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      ref_q     <= reference_raw_i;
      pwr_raw_q <= power_raw_i;
      bat_raw_q <= battery_raw_i;
      now_q     <= now_ms_i;
      cal300_q  <= PW'(cal_q) * PW'(CAL_CENTIVOLTS);
      den_q     <= {reference_raw_i, {SAMPLE_BITS{1'b0}}} - DW'(reference_raw_i);
      pwr_q     <= '0;
      err_q     <= 1'b0;
    end
    if (cmd_i.load) begin
      quo_q <= NW'(cal300_q) * NW'(raw_sel);
      rem_q <= '0;
    end
    if (cmd_i.step) begin
      rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
      quo_q <= {quo_q[NW-2:0], ge};
    end
    if (cmd_i.store) begin
      if (cmd_i.sel_pwr) begin
        pwr_q <= sat_val;
      end else begin
        batt_q <= sat_val;
      end
      err_q <= err_q | sat_err;
    end
    if (cmd_i.publish) begin
      out_batt_q <= batt_q;
      out_pwr_q  <= pwr_q;
      out_err_q  <= err_q;
    end
  end

  // plug debounce
  assign reading = (pwr_q >= batt_q) ? PLUG_IN : PLUG_OUT;
  assign elapsed = now_q - change_q;

  always_comb begin
    prev_d   = reading;
    change_d = change_q;
    acc_d    = acc_q;
    if (reading != prev_q) begin
      change_d = now_q;
    end else if (acc_q != reading && elapsed > lag_q) begin
      acc_d = reading;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= PLUG_UNKNOWN;
      acc_q       <= PLUG_UNKNOWN;
      change_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.publish) begin
        prev_q   <= prev_d;
        acc_q    <= acc_d;
        change_q <= change_d;
      end
      if (cmd_i.publish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // acc_q only moves on publish, which waits until the held result is taken
  assign out_valid_o          = out_valid_q;
  assign battery_centivolts_o = out_batt_q;
  assign power_centivolts_o   = out_pwr_q;
  assign plug_state_o         = acc_q;
  assign range_error_o        = out_err_q;

  assign sts_o.hub      = hub_q;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

endmodule

>>> sv/svpd_checker.sv
`include "supply_voltage_and_plug_detect_macros.svh"

module svpd_checker
  import svpd_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_stall_o,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic [VOLT_BITS-1:0]   battery_centivolts_o,
  input logic [VOLT_BITS-1:0]   power_centivolts_o,
  input logic [1:0]             plug_state_o,
  input logic                   range_error_o
);

  // a stalled result stays offered
  `SVPD_ASSERT_CLK(a_out_hold,
    out_valid_o && out_stall_i |=> out_valid_o,
    "result dropped while stalled")

  // a cycle that starts in reset offers no result
  `SVPD_ASSERT_ANY(a_rst_quiet,
    !rst_ni |=> !out_valid_o,
    "result offered during reset")

  // a range error always comes with a saturated voltage
  `SVPD_ASSERT_CLK(a_err_sat,
    out_valid_o && range_error_o |->
      (battery_centivolts_o == 16'hFFFF || power_centivolts_o == 16'hFFFF),
    "range error without saturated voltage")

  // the plug state is never the unused code
  `SVPD_ASSERT_CLK(a_plug_code,
    out_valid_o |-> plug_state_o != 2'd3,
    "invalid plug state")

  // a conversion never finishes in the cycle after a transaction is taken
  `SVPD_ASSERT_CLK(a_min_latency,
    in_valid_i && !in_stall_o |=> !$rose(out_valid_o),
    "result too early")

endmodule

bind supply_voltage_and_plug_detect svpd_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_svpd_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_valid_i),
  .in_stall_o          (in_stall_o),
  .out_valid_o         (out_valid_o),
  .out_stall_i         (out_stall_i),
  .battery_centivolts_o(battery_centivolts_o),
  .power_centivolts_o  (power_centivolts_o),
  .plug_state_o        (plug_state_o),
  .range_error_o       (range_error_o)
);
